// ===== design/dlcg_pkg.sv =====
// ----------------------------------------------------------------------------
// dlcg_pkg: shared types and constants of the delayed chirp generator
// Register indexes, arithmetic widths, CORDIC arctangent table, cell word.
// ----------------------------------------------------------------------------
package dlcg_pkg;

   // defaults for the top-level parameters
   localparam int INDEX_BITS_DEF  = 24;
   localparam int PHASE_BITS_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   // register widths
   localparam int FREQ_BITS     = 32;
   localparam int CHIRP_BITS    = 48;
   localparam int DELAY_BITS    = 32;
   localparam int CSR_DATA_BITS = 48;
   localparam int CSR_IDX_BITS  = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START_FREQ = 2'd0,
      CSR_HALF_CHIRP = 2'd1,
      CSR_DELAY      = 2'd2
   } csr_index_type;

   // time offset in Q.8 samples, padded so the limb split is fixed
   localparam int T_BITS    = 40;
   localparam int LIMB_BITS = 24;
   localparam int HI_BITS   = T_BITS - LIMB_BITS;
   localparam int PH_BITS   = 40;   // phase bits 63..24 of the Q0.64 phase

   // CORDIC datapath
   localparam int XY_BITS      = 32;
   localparam int Z_BITS       = 32;
   localparam int CORDIC_STEPS = 28;
   localparam logic signed [XY_BITS-1:0] CORDIC_X0 = 32'sd652032874;

   localparam logic signed [Z_BITS-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
      32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
      32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
      32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
      32'sd652,       32'sd326,       32'sd163,       32'sd81,
      32'sd41,        32'sd20,        32'sd10,        32'sd5
   };

   // word handed from cell to cell
   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic signed [Z_BITS-1:0]  z;
      logic                      flip;        // negate results at the end
      logic                      pre_delay;   // index precedes the delay
   } rot_type;

endpackage

// ===== design/dlcg_phase.sv =====
// ----------------------------------------------------------------------------
// dlcg_phase: chirp phase pipeline
// Six stages: offset from delay, limb products, T^2 and F*T, K limb
// products, K*T^2 sum, final phase add. Bubbles collapse stage by stage.
// ----------------------------------------------------------------------------
module dlcg_phase
   import dlcg_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [INDEX_BITS-1:0] in_index,
   input  logic [FREQ_BITS-1:0]  freq_word,
   input  logic [CHIRP_BITS-1:0] chirp_word,
   input  logic [DELAY_BITS-1:0] delay_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [PHASE_BITS-1:0] out_phase,
   output logic                  out_before
);

   localparam int STAGES = 6;

   logic [STAGES-1:0] vld_ff, vld_in, adv;
   logic [STAGES-1:0] bef_ff, bef_in;

   // stage 1
   logic [T_BITS:0]   diff;
   logic [T_BITS-1:0] t_ff;
   // stage 2
   logic [47:0] bb_ff, bb_in;
   logic [38:0] ab_ff, ab_in;
   logic [15:0] aa_ff, aa_in;
   logic [39:0] fb_ff, fb_in;
   logic [15:0] fa_ff, fa_in;
   // stage 3
   logic [63:0]        sq_ff, sq_in;
   logic [PH_BITS-1:0] lin3_ff, lin3_in;
   // stage 4
   logic [47:0]        k00_ff, k00_in;
   logic [39:0]        k01_ff, k01_in, k10_ff, k10_in;
   logic [15:0]        k02_ff, k02_in, k11_ff, k11_in;
   logic [PH_BITS-1:0] lin4_ff;
   // stage 5
   logic [63:0]        q_ff, q_in;
   logic [PH_BITS-1:0] lin5_ff;
   // stage 6
   logic [PH_BITS-1:0]    ph_in;
   logic [PHASE_BITS-1:0] p_ff;

   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int k = STAGES-2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_in = {vld_ff[STAGES-2:0], in_valid};
   assign in_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (adv & vld_in) | (~adv & vld_ff);
      end
   end

   // offset t = n*256 - D, borrow flags the samples before the delay
   assign diff = {1'b0, T_BITS'(in_index) << 8} - (T_BITS+1)'(delay_word);
   assign bef_in = {bef_ff[STAGES-2:0], diff[T_BITS]};

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) bef_ff[k] <= bef_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) t_ff <= diff[T_BITS-1:0];
   end

   // t = a*2^24 + b; keep only the bits that survive the wraps
   always_comb begin
      bb_in = 48'(t_ff[LIMB_BITS-1:0]) * 48'(t_ff[LIMB_BITS-1:0]);
      ab_in = 39'(t_ff[T_BITS-1:LIMB_BITS]) * 39'(t_ff[LIMB_BITS-1:0]);
      aa_in = 16'(t_ff[T_BITS-1:LIMB_BITS]) * 16'(t_ff[T_BITS-1:LIMB_BITS]);
      fb_in = 40'(freq_word) * 40'(t_ff[LIMB_BITS-1:0]);
      fa_in = 16'(freq_word) * 16'(t_ff[T_BITS-1:LIMB_BITS]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         bb_ff <= bb_in;
         ab_ff <= ab_in;
         aa_ff <= aa_in;
         fb_ff <= fb_in;
         fa_ff <= fa_in;
      end
   end

   // t^2 mod 2^64 and F*t mod 2^40
   assign sq_in   = 64'(bb_ff) + {ab_ff, 25'd0} + {aa_ff, 48'd0};
   assign lin3_in = fb_ff + {fa_ff, 24'd0};

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sq_ff   <= sq_in;
         lin3_ff <= lin3_in;
      end
   end

   // K/2 * t^2 limb products
   always_comb begin
      k00_in = 48'(chirp_word[23:0]) * 48'(sq_ff[23:0]);
      k01_in = 40'(chirp_word[23:0]) * 40'(sq_ff[47:24]);
      k10_in = 40'(chirp_word[47:24]) * 40'(sq_ff[23:0]);
      k02_in = 16'(chirp_word[23:0]) * 16'(sq_ff[63:48]);
      k11_in = 16'(chirp_word[47:24]) * 16'(sq_ff[47:24]);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         k00_ff  <= k00_in;
         k01_ff  <= k01_in;
         k10_ff  <= k10_in;
         k02_ff  <= k02_in;
         k11_ff  <= k11_in;
         lin4_ff <= lin3_ff;
      end
   end

   assign q_in = 64'(k00_ff) + {k01_ff + k10_ff, 24'd0} + {k02_ff + k11_ff, 48'd0};

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         q_ff    <= q_in;
         lin5_ff <= lin4_ff;
      end
   end

   // low 24 bits of the linear term are zero, so no carry reaches bit 24
   assign ph_in = lin5_ff + q_ff[63:24];

   always_ff @(posedge clock) begin
      if (adv[5]) p_ff <= ph_in[PH_BITS-1:PH_BITS-PHASE_BITS];
   end

   assign out_valid  = vld_ff[STAGES-1];
   assign out_phase  = p_ff;
   assign out_before = bef_ff[STAGES-1];

endmodule

// ===== design/dlcg_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// dlcg_cordic_cell: one rotation step of the CORDIC chain
// Registered micro-rotation by atan(2^-STEP), with its own valid/ready.
// ----------------------------------------------------------------------------
module dlcg_cordic_cell
   import dlcg_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  rot_type up_word,
   output logic    dn_valid,
   input  logic    dn_ready,
   output rot_type dn_word
);

   logic    valid_ff;
   rot_type word_ff, word_in;
   logic signed [XY_BITS-1:0] dx, dy;

   assign up_ready = !valid_ff || dn_ready;

   // arithmetic shifts floor, matching the step definition
   assign dx = up_word.y >>> STEP;
   assign dy = up_word.x >>> STEP;

   always_comb begin
      word_in = up_word;
      if (!up_word.z[Z_BITS-1]) begin
         word_in.x = up_word.x - dx;
         word_in.y = up_word.y + dy;
         word_in.z = up_word.z - ATAN_TABLE[STEP];
      end else begin
         word_in.x = up_word.x + dx;
         word_in.y = up_word.y - dy;
         word_in.z = up_word.z + ATAN_TABLE[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) word_ff <= word_in;
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

// ===== design/delayed_lfm_chirp_sample_generator.sv =====
// ----------------------------------------------------------------------------
// delayed_lfm_chirp_sample_generator: quadrature LFM chirp sample source
// Delayed chirp phase, a chain of CORDIC cells, rounding to I/Q samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word per sample index, valid/ready handshake.
//   rsp_ channel: one word per request, in order: in_phase, quadrature
//     (signed Q1.(SAMPLE_BITS-1)) and before_delay.
//   csr_ port: write-only, csr_we with csr_index/csr_wdata; index 0 is
//     the start frequency, 1 the half chirp rate, 2 the Q24.8 delay.
//     Write only while no request is in flight.
// Pipeline: six phase stages, 28 CORDIC cells, one rounding/output
//   register, from request accept to response valid.
// Throughput: one word per cycle while rsp_ready keeps up, set by the
//   fully pipelined phase multipliers and the one-step-per-cell CORDIC chain.
// Stalls: each stage holds its word while the next one is full and not
//   moving; empty stages still fill, so requests are taken while a
//   response waits until the whole pipe is full.
// Reset: synchronous, clears all valid flags and the three registers.
// ----------------------------------------------------------------------------
module delayed_lfm_chirp_sample_generator
   import dlcg_pkg::*;
#(
   parameter int INDEX_BITS  = INDEX_BITS_DEF,
   parameter int PHASE_BITS  = PHASE_BITS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [INDEX_BITS-1:0]         req_sample_index,
   // response
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_in_phase,
   output logic signed [SAMPLE_BITS-1:0] rsp_quadrature,
   output logic                          rsp_before_delay,
   // configuration
   input  logic                          csr_we,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int RND_SHIFT = 31 - SAMPLE_BITS;
   localparam logic signed [XY_BITS:0] RND_HALF = (XY_BITS+1)'(1) <<< (RND_SHIFT - 1);
   localparam logic signed [XY_BITS:0] SAT_HI =
      (XY_BITS+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [XY_BITS:0] SAT_LO = -SAT_HI - 1;

   // configuration registers
   logic [FREQ_BITS-1:0]  freq_ff;
   logic [CHIRP_BITS-1:0] chirp_ff;
   logic [DELAY_BITS-1:0] delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= '0;
         chirp_ff <= '0;
         delay_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_FREQ: freq_ff  <= csr_wdata[FREQ_BITS-1:0];
            CSR_HALF_CHIRP: chirp_ff <= csr_wdata[CHIRP_BITS-1:0];
            CSR_DELAY:      delay_ff <= csr_wdata[DELAY_BITS-1:0];
            default: ;      // unused index, write dropped
         endcase
      end
   end

   // phase front end
   logic                  ph_valid, ph_ready, ph_before;
   logic [PHASE_BITS-1:0] ph_phase;

   dlcg_phase #(
      .INDEX_BITS (INDEX_BITS),
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_index   (req_sample_index),
      .freq_word  (freq_ff),
      .chirp_word (chirp_ff),
      .delay_word (delay_ff),
      .out_valid  (ph_valid),
      .out_ready  (ph_ready),
      .out_phase  (ph_phase),
      .out_before (ph_before)
   );

   // quadrant fold: second and third quadrants rotate by half a cycle,
   // results get negated at the end
   logic [Z_BITS-1:0] z_raw;
   rot_type           seed;

   assign z_raw = Z_BITS'(ph_phase) << (Z_BITS - PHASE_BITS);

   always_comb begin
      seed.x         = CORDIC_X0;
      seed.y         = '0;
      seed.flip      = z_raw[Z_BITS-1] ^ z_raw[Z_BITS-2];
      seed.z         = seed.flip ? $signed({~z_raw[Z_BITS-1], z_raw[Z_BITS-2:0]})
                                 : $signed(z_raw);
      seed.pre_delay = ph_before;
   end

   // CORDIC chain
   logic    cv [CORDIC_STEPS+1];
   logic    cr [CORDIC_STEPS+1];
   rot_type cw [CORDIC_STEPS+1];

   assign cv[0]    = ph_valid;
   assign cw[0]    = seed;
   assign ph_ready = cr[0];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      dlcg_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cv[i]),
         .up_ready (cr[i]),
         .up_word  (cw[i]),
         .dn_valid (cv[i+1]),
         .dn_ready (cr[i+1]),
         .dn_word  (cw[i+1])
      );
   end

   // round Q2.30 to sample width, negate for folded quadrants, saturate
   function automatic logic [SAMPLE_BITS-1:0] to_sample(
      input logic signed [XY_BITS-1:0] v,
      input logic                      neg
   );
      logic signed [XY_BITS:0] r;
      r = ($signed({v[XY_BITS-1], v}) + RND_HALF) >>> RND_SHIFT;
      if (neg) r = -r;
      if (r > SAT_HI) r = SAT_HI;
      else if (r < SAT_LO) r = SAT_LO;
      return r[SAMPLE_BITS-1:0];
   endfunction

   // output register
   logic                   out_valid_ff, out_adv;
   logic [SAMPLE_BITS-1:0] i_ff, i_in, q_ff, q_in;
   logic                   bef_ff;

   assign out_adv = !out_valid_ff || rsp_ready;
   assign cr[CORDIC_STEPS] = out_adv;

   assign i_in = cw[CORDIC_STEPS].pre_delay ? '0
               : to_sample(cw[CORDIC_STEPS].x, cw[CORDIC_STEPS].flip);
   assign q_in = cw[CORDIC_STEPS].pre_delay ? '0
               : to_sample(cw[CORDIC_STEPS].y, cw[CORDIC_STEPS].flip);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= cv[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         i_ff   <= i_in;
         q_ff   <= q_in;
         bef_ff <= cw[CORDIC_STEPS].pre_delay;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_in_phase     = $signed(i_ff);
   assign rsp_quadrature   = $signed(q_ff);
   assign rsp_before_delay = bef_ff;

`ifndef SYNTHESIS
   // samples ahead of the delay carry no signal
   a_before_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_before_delay |-> rsp_in_phase == '0 && rsp_quadrature == '0)
      else $error("nonzero sample flagged before delay");

   // an empty output register lets the whole pipe move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
